// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/sma_pkg.sv =====
// ----------------------------------------------------------------------------
// sma_pkg
// shared constants, state types and helpers of the moving average unit
// ----------------------------------------------------------------------------
package sma_pkg;

	localparam int MAX_WINDOW = 256;
	localparam int PTR_W      = $clog2(MAX_WINDOW);
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
	localparam int WIN_W      = 9;
	localparam int DATA_W     = 32;
	localparam int SUM_W      = 40;
	localparam int DIV_CNT_W  = $clog2(SUM_W + 1);

	localparam logic [SUM_W-1:0]  POS_LIMIT = SUM_W'(64'h7FFF_FFFF);
	localparam logic [SUM_W-1:0]  NEG_LIMIT = SUM_W'(64'h8000_0000);
	localparam logic [DATA_W-1:0] POS_SAT   = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] NEG_SAT   = 32'h8000_0000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUB,
		ST_ADD,
		ST_DIVS,
		ST_DIVW,
		ST_DONE
	} sma_state_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_RUN,
		DV_FIN
	} div_state_t;

	// zero means a window of one, anything above the ring depth is clamped
	function automatic logic [CNT_W-1:0] eff_len(input logic [WIN_W-1:0] w);
		logic [CNT_W-1:0] r;
		if (int'(w) > MAX_WINDOW)
			r = CNT_W'(MAX_WINDOW);
		else if (w == '0)
			r = CNT_W'(1);
		else
			r = CNT_W'(w);
		return r;
	endfunction

endpackage

// ===== src/sma_div.sv =====
// ----------------------------------------------------------------------------
// sma_div
// serial signed divide of the window sum by the window length, one bit a cycle
// ----------------------------------------------------------------------------
module sma_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [sma_pkg::SUM_W-1:0]    dividend,
	input  logic [sma_pkg::CNT_W-1:0]    divisor,
	output logic                         done,
	output logic [sma_pkg::DATA_W-1:0]   quotient
);
	import sma_pkg::*;

	div_state_t           state_q, state_d;
	logic                 neg_q;
	logic [SUM_W-1:0]     quo_q;
	logic [CNT_W-1:0]     rem_q;
	logic [CNT_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [DATA_W-1:0]    res_q;
	logic [CNT_W:0]       trial;
	logic                 fits;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= DV_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DV_IDLE: if (start) state_d = DV_RUN;
			DV_RUN:  if (cnt_q == DIV_CNT_W'(SUM_W - 1)) state_d = DV_FIN;
			DV_FIN:  state_d = DV_IDLE;
			default: state_d = DV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= (state_q == DV_FIN);
	end

	// datapath, magnitude taken on load
	always_ff @(posedge clk) begin
		unique case (state_q)
			DV_IDLE: begin
				if (start) begin
					neg_q <= dividend[SUM_W-1];
					quo_q <= dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
					rem_q <= '0;
					dvs_q <= divisor;
					cnt_q <= '0;
				end
			end
			DV_RUN: begin
				rem_q <= fits ? CNT_W'(trial - {1'b0, dvs_q}) : CNT_W'(trial);
				quo_q <= {quo_q[SUM_W-2:0], fits};
				cnt_q <= cnt_q + DIV_CNT_W'(1);
			end
			DV_FIN: begin
				if (neg_q)
					res_q <= (quo_q > NEG_LIMIT) ? NEG_SAT : DATA_W'(~quo_q + SUM_W'(1));
				else
					res_q <= (quo_q > POS_LIMIT) ? POS_SAT : quo_q[DATA_W-1:0];
			end
			default: ;
		endcase
	end

	assign done     = done_q;
	assign quotient = res_q;

endmodule

// ===== src/simple_moving_average_unit.sv =====
// ----------------------------------------------------------------------------
// simple_moving_average_unit
// moving average of signed q16.16 samples over a programmable window
// ----------------------------------------------------------------------------
//
//  channel   direction  signals                       contents
//  s_*       in         s_tvalid s_tready s_tdata     sample, tuser = series_start
//                       s_tuser
//  m_*       out        m_tvalid m_tready m_tdata     average, tuser = valid_res
//                       m_tuser
//  cfg_*     in         cfg_valid cfg_ready cfg_data  window_length
//
//  the unit takes one item at a time: after an input transfer it runs the sub and
//  add states, then, when the window is full, the one bit a cycle divide of the
//  40-bit sum, and then waits in the done state for the output register; the
//  divide is skipped when the result is not yet valid
//  ring read and write go through a single synchronous memory port pair
//  arst_n clears the sum, pointer, count and window length (to 1); the ring is
//  not cleared, entries are only read once written in the current series
//  a stalled m_tready holds the finished result in the output register; only
//  a second finished result waits for it to drain
//
module simple_moving_average_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	// input stream
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [31:0]                s_tdata,   // [31:0] sample
	input  logic [0:0]                 s_tuser,   // [0] series_start
	// result stream
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [31:0]                m_tdata,   // [31:0] average
	output logic [0:0]                 m_tuser,   // [0] valid_res
	// window length register
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [sma_pkg::WIN_W-1:0]  cfg_data
);
	import sma_pkg::*;

	`include "assert_macros.svh"

	// control state
	sma_state_t        state_q, state_d;
	logic [WIN_W-1:0]  win_q;
	logic [SUM_W-1:0]  sum_q;
	logic [PTR_W-1:0]  wptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              m_valid_q;

	// per item registers
	logic [DATA_W-1:0] sample_q;
	logic [CNT_W-1:0]  len_q;
	logic              need_sub_q;
	logic              res_valid_q;
	logic [DATA_W-1:0] avg_q;
	logic [DATA_W-1:0] m_data_q;
	logic              m_user_q;

	// ring memory, read data registered
	logic [DATA_W-1:0] ring_mem [MAX_WINDOW];
	logic [DATA_W-1:0] ring_rd_s1;
	logic [PTR_W-1:0]  rd_addr;

	// handshakes and strobes
	logic              in_xfer;
	logic              out_load;
	logic              ring_we;
	logic              div_start;
	logic              div_done;
	logic [DATA_W-1:0] div_quo;

	logic [CNT_W-1:0]  len_now;
	logic [CNT_W-1:0]  cnt_base;
	logic [CNT_W-1:0]  cnt_next;
	logic              valid_next;

	assign cfg_ready = 1'b1;
	assign in_xfer   = s_tvalid && s_tready;

	// figures for the item being taken
	assign len_now  = eff_len(win_q);
	assign cnt_base = s_tuser[0] ? '0 : count_q;
	// oldest sample of the window sits len entries behind the write pointer
	assign rd_addr  = wptr_q - len_now[PTR_W-1:0];

	assign cnt_next   = (count_q < CNT_W'(MAX_WINDOW)) ? count_q + CNT_W'(1) : count_q;
	assign valid_next = cnt_next >= len_q;

	// --------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		ring_we   = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = ST_SUB;
			end
			ST_SUB: state_d = ST_ADD;
			ST_ADD: begin
				ring_we = 1'b1;
				state_d = valid_next ? ST_DIVS : ST_DONE;
			end
			ST_DIVS: begin
				div_start = 1'b1;
				state_d   = ST_DIVW;
			end
			ST_DIVW: if (div_done) state_d = ST_DONE;
			ST_DONE: begin
				// wait for the output register to be free or draining
				if (!m_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// --------------------------------------------------------------- control regs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q     <= WIN_W'(1);
			sum_q     <= '0;
			wptr_q    <= '0;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				win_q <= cfg_data;
			// a series start clears count and sum before the sample goes in
			if (in_xfer) begin
				count_q <= cnt_base;
				if (s_tuser[0])
					sum_q <= '0;
			end
			// drop the sample leaving the window
			if (state_q == ST_SUB && need_sub_q)
				sum_q <= sum_q - {{(SUM_W-DATA_W){ring_rd_s1[DATA_W-1]}}, ring_rd_s1};
			if (state_q == ST_ADD) begin
				sum_q   <= sum_q + {{(SUM_W-DATA_W){sample_q[DATA_W-1]}}, sample_q};
				wptr_q  <= wptr_q + PTR_W'(1);
				count_q <= cnt_next;
			end
			if (out_load)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	// --------------------------------------------------------------- payload regs
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_q   <= s_tdata;
			len_q      <= len_now;
			need_sub_q <= cnt_base >= len_now;
		end
		if (state_q == ST_ADD) begin
			res_valid_q <= valid_next;
			avg_q       <= '0;
		end
		if (state_q == ST_DIVW && div_done)
			avg_q <= div_quo;
		if (out_load) begin
			m_data_q <= avg_q;
			m_user_q <= res_valid_q;
		end
	end

	// --------------------------------------------------------------- sample ring
	// read-before-write; the read is issued on the input transfer, the write lands
	// in the add state after the sub state, so the two never meet within one item
	always_ff @(posedge clk) begin
		if (ring_we)
			ring_mem[wptr_q] <= sample_q;
		ring_rd_s1 <= ring_mem[rd_addr];
	end

	// --------------------------------------------------------------- divider
	sma_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (len_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = m_data_q;
	assign m_tuser[0] = m_user_q;

	// --------------------------------------------------------------- checks
	`ASSERT_NEXT(a_one_item_at_a_time, in_xfer, !s_tready, "input taken twice in a row")
	`ASSERT_SAME(a_invalid_is_zero, m_tvalid && !m_tuser[0], m_tdata == '0, "invalid result not zero")
	`ASSERT_SAME(a_count_bound, 1'b1, count_q <= CNT_W'(MAX_WINDOW), "sample count beyond ring depth")
	`ASSERT_SAME(a_div_done_waited, div_done, state_q == ST_DIVW, "divide finished while not awaited")

endmodule

// ===== dv/simple_moving_average_unit_tb.sv =====
// ----------------------------------------------------------------------------
// simple_moving_average_unit_tb
// self-checking bench for the moving average unit: a directed table walks the
// sample extremes, zero and clamped windows, short series, window changes in
// mid series and quotient saturation, then random series run under several
// window lengths; every result transfer is checked field by field against the
// expected result typed in its directed row or else a local moving average predictor
// ----------------------------------------------------------------------------
module simple_moving_average_unit_tb;

	localparam int CYCLE_LIMIT   = 400000;  // about ten times the slowest correct run
	localparam int SETTLE_CYCLES = 50;      // longer than an item occupies the unit, divide included
	localparam int TAIL_CYCLES   = 60;
	localparam int NUM_DIRECTED  = 27;

	typedef struct packed {
		logic [31:0] average;
		logic        valid_res;
	} avg_result_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	// one row of the directed table: a sample or a window write
	typedef struct packed {
		row_kind_t   kind;
		logic [8:0]  win;
		logic [31:0] smp;
		logic        start;
		logic        typed;     // expected result written in the row
		logic [31:0] avg;
		logic        vld;
	} stim_row_t;

	localparam avg_result_t NO_RESULT = '{average: '0, valid_res: 1'b0};

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [31:0]               s_tdata = '0;    // [31:0] sample
	logic [0:0]                s_tuser = '0;    // [0] series_start
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [31:0]               m_tdata;         // [31:0] average
	logic [0:0]                m_tuser;         // [0] valid_res
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [sma_pkg::WIN_W-1:0] cfg_data = '0;

	simple_moving_average_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// predictor state
	logic [31:0]               hist_ring [sma_pkg::MAX_WINDOW];
	logic [sma_pkg::SUM_W-1:0] win_sum;
	logic [7:0]                wr_ptr;
	logic [8:0]                seen;
	logic [sma_pkg::WIN_W-1:0] win_reg;

	avg_result_t averages_due [$];
	bit          allow_idle = 1'b1;
	int          mismatches = 0;
	int          results_seen = 0;
	int          samples_sent = 0;
	int          settings_used = 0;
	int          cycle_count = 0;
	int          rx_hold = 0;

	stim_row_t directed [NUM_DIRECTED] = '{
		// window of one after reset: the average is the sample itself
		'{ROW_ITEM, 9'd0,   32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b1},
		'{ROW_ITEM, 9'd0,   32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000, 1'b1},
		'{ROW_ITEM, 9'd0,   32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b1},
		'{ROW_ITEM, 9'd0,   32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1},
		// zero window behaves as one
		'{ROW_CFG,  9'd0,   32'h0,         1'b0, 1'b0, 32'h0,         1'b0},
		'{ROW_ITEM, 9'd0,   32'h1234_5678, 1'b1, 1'b1, 32'h1234_5678, 1'b1},
		'{ROW_ITEM, 9'd0,   32'h0001_0000, 1'b0, 1'b1, 32'h0001_0000, 1'b1},
		// window of three, first two results not valid
		'{ROW_CFG,  9'd3,   32'h0,         1'b0, 1'b0, 32'h0,         1'b0},
		'{ROW_ITEM, 9'd0,   32'h0003_0000, 1'b1, 1'b1, 32'h0,         1'b0},
		'{ROW_ITEM, 9'd0,   32'h0006_0000, 1'b0, 1'b1, 32'h0,         1'b0},
		'{ROW_ITEM, 9'd0,   32'h0000_0003, 1'b0, 1'b0, 32'h0,         1'b0},
		'{ROW_ITEM, 9'd0,   32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0,         1'b0},
		'{ROW_ITEM, 9'd0,   32'h8000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
		'{ROW_ITEM, 9'd0,   32'h8000_0000, 1'b1, 1'b1, 32'h0,         1'b0},
		'{ROW_ITEM, 9'd0,   32'h8000_0000, 1'b0, 1'b1, 32'h0,         1'b0},
		'{ROW_ITEM, 9'd0,   32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000, 1'b1},
		// shrink to one in mid series: sum of three minima saturates low
		'{ROW_CFG,  9'd1,   32'h0,         1'b0, 1'b0, 32'h0,         1'b0},
		'{ROW_ITEM, 9'd0,   32'h8000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
		'{ROW_CFG,  9'd3,   32'h0,         1'b0, 1'b0, 32'h0,         1'b0},
		'{ROW_ITEM, 9'd0,   32'h7FFF_FFFF, 1'b1, 1'b1, 32'h0,         1'b0},
		'{ROW_ITEM, 9'd0,   32'h7FFF_FFFF, 1'b0, 1'b1, 32'h0,         1'b0},
		'{ROW_ITEM, 9'd0,   32'h7FFF_FFFF, 1'b0, 1'b1, 32'h7FFF_FFFF, 1'b1},
		// same for the positive side
		'{ROW_CFG,  9'd1,   32'h0,         1'b0, 1'b0, 32'h0,         1'b0},
		'{ROW_ITEM, 9'd0,   32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0,         1'b0},
		// window above the ring depth is clamped
		'{ROW_CFG,  9'd511, 32'h0,         1'b0, 1'b0, 32'h0,         1'b0},
		'{ROW_ITEM, 9'd0,   32'h0000_0001, 1'b0, 1'b0, 32'h0,         1'b0},
		'{ROW_ITEM, 9'd0,   32'h0000_0001, 1'b1, 1'b0, 32'h0,         1'b0}
	};

	// advance the predictor by one sample and return the average it gives
	function automatic avg_result_t average_step(input logic [31:0] smp, input logic start);
		logic [8:0]                len;
		logic [7:0]                old_idx;
		logic [sma_pkg::SUM_W-1:0] mag;
		logic [sma_pkg::SUM_W-1:0] quo;
		avg_result_t               r;
		if (win_reg == '0)
			len = 9'd1;
		else if (win_reg > 9'd256)
			len = 9'd256;
		else
			len = win_reg;
		if (start) begin
			seen = '0;
			win_sum = '0;
		end
		// sample leaving the window, 256 folds onto the write pointer
		if (seen >= len) begin
			old_idx = wr_ptr - len[7:0];
			win_sum = win_sum - {{8{hist_ring[old_idx][31]}}, hist_ring[old_idx]};
		end
		win_sum = win_sum + {{8{smp[31]}}, smp};
		hist_ring[wr_ptr] = smp;
		wr_ptr = wr_ptr + 8'd1;
		if (seen < 9'd256)
			seen = seen + 9'd1;
		r = NO_RESULT;
		if (seen >= len) begin
			r.valid_res = 1'b1;
			mag = win_sum[39] ? -win_sum : win_sum;
			quo = mag / {31'd0, len};
			if (win_sum[39]) begin
				if (quo > 40'h80_0000_0000 >> 8)
					quo = 40'h00_8000_0000;
				r.average = -quo[31:0];
			end else begin
				if (quo > 40'h00_7FFF_FFFF)
					quo = 40'h00_7FFF_FFFF;
				r.average = quo[31:0];
			end
		end
		return r;
	endfunction

	task automatic log_mismatch(input string what, input logic [31:0] want,
	                            input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch in %s at result %0d: expected %h, got %h",
			         what, results_seen, want, got);
	endtask

	// one sample transfer, with an optional gap before it
	task automatic push_sample(input logic [31:0] smp, input logic start, input logic typed,
	                           input avg_result_t typed_res);
		int          gap;
		avg_result_t predicted;
		@(negedge clk);
		if (allow_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		s_tuser  <= start;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = average_step(smp, start);
		averages_due.push_back(typed ? typed_res : predicted);
		samples_sent++;
	endtask

	// window writes only once the unit has drained
	task automatic write_window(input logic [sma_pkg::WIN_W-1:0] w);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (averages_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= w;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		win_reg = w;
		settings_used++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// random series under one window setting; fresh opens a new series
	task automatic run_phase(input logic [sma_pkg::WIN_W-1:0] w, input int n, input bit fresh,
	                         input bit quiet);
		logic [31:0] smp;
		logic        start;
		write_window(w);
		allow_idle = !quiet && ($urandom_range(0, 3) != 0);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 7))
				0: smp = 32'h7FFF_FFFF;
				1: smp = 32'h8000_0000;
				2: begin
					smp = $urandom_range(0, 32'h0007_FFFF);
					if ($urandom_range(0, 1) == 1)
						smp = -smp;
				end
				3: smp = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
				default: smp = $urandom();
			endcase
			// new series are rare so that most run well past a full window
			start = (i == 0 && fresh) || ($urandom_range(0, 4 * int'(w) + 16) == 0);
			push_sample(smp, start, 1'b0, NO_RESULT);
		end
	endtask

	// result side stalls in random bursts while allow_idle is set
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold--;
			m_tready <= 1'b0;
		end else if (allow_idle && $urandom_range(0, 7) == 0) begin
			rx_hold = $urandom_range(1, 8) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// result transfers against the oldest expected average
	always @(posedge clk) begin : result_check
		avg_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (averages_due.size() == 0) begin
				log_mismatch("unexpected result (average)", '0, m_tdata);
			end else begin
				want = averages_due.pop_front();
				if (m_tdata !== want.average)
					log_mismatch("average", want.average, m_tdata);
				if (m_tuser[0] !== want.valid_res)
					log_mismatch("valid_res", 32'(want.valid_res), 32'(m_tuser[0]));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
			         cycle_count, averages_due.size());
			$display("simple_moving_average_unit test failed");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < sma_pkg::MAX_WINDOW; i++)
			hist_ring[i] = '0;
		win_sum = '0;
		wr_ptr  = '0;
		seen    = '0;
		win_reg = 9'd1;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			if (directed[i].kind == ROW_CFG)
				write_window(directed[i].win);
			else
				push_sample(directed[i].smp, directed[i].start, directed[i].typed,
				            '{average: directed[i].avg, valid_res: directed[i].vld});
		end

		run_phase(9'd3,   50,  1'b1, 1'b0);
		run_phase(9'd256, 270, 1'b1, 1'b0);
		// clamped window carries on the full series
		run_phase(9'd511, 30,  1'b0, 1'b0);
		// zero window in mid series
		run_phase(9'd0,   20,  1'b0, 1'b0);
		run_phase(9'd8,   50,  1'b1, 1'b0);
		run_phase(9'($urandom_range(2, 40)),  60, 1'b1, 1'b0);
		run_phase(9'($urandom_range(1, 300)), 60, 1'b1, 1'b0);
		run_phase(9'd5,   60,  1'b1, 1'b1);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (averages_due.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d samples sent over %0d window writes, %0d averages checked",
		         samples_sent, settings_used, results_seen);
		$display("%0d mismatches, %0d averages never delivered",
		         mismatches, averages_due.size());
		if (mismatches == 0 && averages_due.size() == 0) begin
			$display("simple_moving_average_unit test passed");
		end else begin
			$display("simple_moving_average_unit test failed");
		end
		$finish;
	end

endmodule
